// ----- rtl/ray_triangle_hit_list_defines.svh -----
// Assertion macros for the ray and triangle hit list checker.
// Needs clk and rst_n visible where the macros are used.
`ifndef RAY_TRIANGLE_HIT_LIST_DEFINES_SVH
`define RAY_TRIANGLE_HIT_LIST_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge
`define RTHL_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rthl check failed");

// Next-cycle implication
`define RTHL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rthl check failed");

`endif

// ----- rtl/rthl_pkg.sv -----
// Shared types, constants and helpers for the ray and triangle hit list.
// No dependencies.
package rthl_pkg;

    localparam int MAX_TRI_DEF = 64;

    // Item kinds
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_ORIGIN = 2'd1;
    localparam logic [1:0] KIND_CAST   = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    // Triangle vector parts
    localparam logic [1:0] PART_ANCHOR = 2'd0;
    localparam logic [1:0] PART_EDGE1  = 2'd1;
    localparam logic [1:0] PART_EDGE2  = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_TRI_IN_USE = 2'd0;
    localparam logic [1:0] REG_HIT_CAP    = 2'd1;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef logic signed [31:0]  coord_t;
    typedef logic signed [32:0]  wv_t;
    typedef logic signed [65:0]  opa_t;
    typedef logic signed [103:0] acc_t;

    typedef coord_t vec_t [3];
    typedef wv_t    opb_vec_t [3];
    typedef opa_t   opa_vec_t [3];

    // Pipeline tag: travels with a triangle under test
    typedef struct packed {
        logic       valid;
        logic [5:0] tri_idx;
    } tag_t;

    // Test outcome handed back to the sequencer
    typedef struct packed {
        logic       valid;
        logic       hit;
        logic [5:0] tri_idx;
    } hit_t;

    // One component of a packed xyz word
    function automatic coord_t comp(input logic [95:0] v, input int k);
        return coord_t'(v[k*32 +: 32]);
    endfunction

    // 33 x 33 signed product at full width
    function automatic opa_t mul33(input wv_t a, input wv_t b);
        opa_t r;
        r = a * b;
        return r;
    endfunction

endpackage

// ----- rtl/rthl_cell.sv -----
// One multiply-accumulate cell of a systolic dot product chain.
// Depends on rthl_pkg.
module rthl_cell #(
    parameter int POS = 0
) (
    input  logic              clk,
    input  rthl_pkg::opa_vec_t a_in,
    input  rthl_pkg::opb_vec_t b_in,
    input  rthl_pkg::acc_t     sum_in,
    output rthl_pkg::opa_vec_t a_out,
    output rthl_pkg::opb_vec_t b_out,
    output rthl_pkg::acc_t     sum_out
);
    import rthl_pkg::*;

    opa_vec_t a_reg;
    opb_vec_t b_reg;
    logic        [32:0] a_lo;
    logic signed [32:0] a_hi;
    logic signed [66:0] plo_next, plo_reg;
    logic signed [65:0] phi_next, phi_reg;
    acc_t sum_reg;

    // Split the wide operand so each multiplier stays near 33 x 33
    assign a_lo     = a_in[POS][32:0];
    assign a_hi     = a_in[POS][65:33];
    assign plo_next = $signed({1'b0, a_lo}) * b_in[POS];
    assign phi_next = a_hi * b_in[POS];

    // Products first, then add to the neighbour's partial sum
    always_ff @(posedge clk)
    begin
        a_reg   <= a_in;
        b_reg   <= b_in;
        plo_reg <= plo_next;
        phi_reg <= phi_next;
        sum_reg <= sum_in + (acc_t'(phi_reg) <<< 33) + acc_t'(plo_reg);
    end

    assign a_out   = a_reg;
    assign b_out   = b_reg;
    assign sum_out = sum_reg;

endmodule

// ----- rtl/rthl_dot.sv -----
// Three-term dot product as a chain of three cells.
// Depends on rthl_pkg and rthl_cell.
module rthl_dot (
    input  logic               clk,
    input  rthl_pkg::opa_vec_t a,
    input  rthl_pkg::opb_vec_t b,
    output rthl_pkg::acc_t     sum
);
    import rthl_pkg::*;

    opa_vec_t a_ch [4];
    opb_vec_t b_ch [4];
    acc_t     s_ch [4];

    assign a_ch[0] = a;
    assign b_ch[0] = b;
    assign s_ch[0] = '0;

    for (genvar k = 0; k < 3; k++)
    begin : g_cell
        rthl_cell #(.POS(k)) u_cell (
            .clk    (clk),
            .a_in   (a_ch[k]),
            .b_in   (b_ch[k]),
            .sum_in (s_ch[k]),
            .a_out  (a_ch[k+1]),
            .b_out  (b_ch[k+1]),
            .sum_out(s_ch[k+1])
        );
    end

    assign sum = s_ch[3];

endmodule

// ----- rtl/rthl_test.sv -----
// Pipelined ray and triangle test: offset, cross products, four dot chains, sign test.
// Depends on rthl_pkg and rthl_dot.
module rthl_test (
    input  logic             clk,
    input  logic             rst_n,
    input  rthl_pkg::tag_t   tag_in,
    input  logic [95:0]      anc,
    input  logic [95:0]      e1,
    input  logic [95:0]      e2,
    input  rthl_pkg::vec_t   org,
    input  rthl_pkg::vec_t   dir,
    output rthl_pkg::hit_t   res,
    output logic             pipe_busy
);
    import rthl_pkg::*;

    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};

    tag_t tag_a_reg, tag_b_reg, tag_c_reg;
    tag_t tag_d_reg [4];
    hit_t res_reg;

    opb_vec_t w_a_reg, e1_a_reg, e2_a_reg, w_b_reg, w_c_reg, dir_w;
    opa_t pn_reg [6];
    opa_t pu_reg [6];
    opa_t pv_reg [6];
    opa_vec_t n_reg, u_reg, v_reg;
    acc_t p_d, p_t, p_a, p_b;
    acc_t d_val, e_val;
    logic hit_next;

    // Stage A: offset from anchor, widen edges
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            w_a_reg[k]  <= wv_t'(org[k]) - wv_t'(comp(anc, k));
            e1_a_reg[k] <= wv_t'(comp(e1, k));
            e2_a_reg[k] <= wv_t'(comp(e2, k));
        end
    end

    // Stage B: cross product terms
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            pn_reg[2*k]   <= mul33(e1_a_reg[NXT[k]], e2_a_reg[PRV[k]]);
            pn_reg[2*k+1] <= mul33(e1_a_reg[PRV[k]], e2_a_reg[NXT[k]]);
            pu_reg[2*k]   <= mul33(e2_a_reg[NXT[k]], w_a_reg[PRV[k]]);
            pu_reg[2*k+1] <= mul33(e2_a_reg[PRV[k]], w_a_reg[NXT[k]]);
            pv_reg[2*k]   <= mul33(w_a_reg[NXT[k]], e1_a_reg[PRV[k]]);
            pv_reg[2*k+1] <= mul33(w_a_reg[PRV[k]], e1_a_reg[NXT[k]]);
        end
        w_b_reg <= w_a_reg;
    end

    // Stage C: n = e1 x e2, u = e2 x w, v = w x e1
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            n_reg[k] <= pn_reg[2*k] - pn_reg[2*k+1];
            u_reg[k] <= pu_reg[2*k] - pu_reg[2*k+1];
            v_reg[k] <= pv_reg[2*k] - pv_reg[2*k+1];
        end
        w_c_reg <= w_b_reg;
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dir_w[k] = wv_t'(dir[k]);
        end
    end

    // Four dot chains in parallel
    rthl_dot u_dot_d (.clk(clk), .a(n_reg), .b(dir_w),   .sum(p_d));
    rthl_dot u_dot_t (.clk(clk), .a(n_reg), .b(w_c_reg), .sum(p_t));
    rthl_dot u_dot_a (.clk(clk), .a(u_reg), .b(dir_w),   .sum(p_a));
    rthl_dot u_dot_b (.clk(clk), .a(v_reg), .b(dir_w),   .sum(p_b));

    // Sign test; d = -(n . dir), e = d - an - bn
    always_comb
    begin
        d_val = -p_d;
        e_val = d_val - p_a - p_b;
        if (d_val == '0)
        begin
            hit_next = 1'b0;
        end
        else if (!d_val[103])
        begin
            hit_next = !p_t[103] && (p_t != '0) && !p_a[103] && !p_b[103] && !e_val[103];
        end
        else
        begin
            hit_next = p_t[103] && (p_a[103] || p_a == '0) && (p_b[103] || p_b == '0)
                       && (e_val[103] || e_val == '0);
        end
    end

    // Tag line alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
            for (int k = 0; k < 4; k++)
            begin
                tag_d_reg[k] <= '0;
            end
            res_reg <= '0;
        end
        else
        begin
            tag_a_reg    <= tag_in;
            tag_b_reg    <= tag_a_reg;
            tag_c_reg    <= tag_b_reg;
            tag_d_reg[0] <= tag_c_reg;
            for (int k = 1; k < 4; k++)
            begin
                tag_d_reg[k] <= tag_d_reg[k-1];
            end
            res_reg.valid   <= tag_d_reg[3].valid;
            res_reg.hit     <= hit_next;
            res_reg.tri_idx <= tag_d_reg[3].tri_idx;
        end
    end

    assign res       = res_reg;
    assign pipe_busy = tag_a_reg.valid | tag_b_reg.valid | tag_c_reg.valid
                     | tag_d_reg[0].valid | tag_d_reg[1].valid | tag_d_reg[2].valid
                     | tag_d_reg[3].valid | res_reg.valid;

endmodule

// ----- rtl/ray_triangle_hit_list.sv -----
// Top level of the ray and triangle hit list: triangle memories, cast sequencer, hit output.
// Depends on rthl_pkg and rthl_test.
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+---------------------------------------------
//  item in | start, busy             | kind, tri_slot, vector_part, ray_number, coords
//  config  | cfg_valid, cfg_ready    | cfg_index, cfg_data
//  hits    | hit_valid (strobe only) | hit_ray, hit_triangle, hit_slot, last_hit
//
// Load, origin and clear items leave the block idle. A cast issues one triangle per
// cycle from the memories into the test pipeline and stays busy until it drains.
// Reset clears counters, the origin, the direction and the triangles-in-use count,
// and sets the hit cap to its maximum; triangle memories are not cleared.
// Hits leave on a one-cycle strobe; the receiver cannot stall them.
module ray_triangle_hit_list #(
    parameter int MAX_TRIANGLES = rthl_pkg::MAX_TRI_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          kind,
    input  logic [5:0]          tri_slot,
    input  logic [1:0]          vector_part,
    input  logic [15:0]         ray_number,
    input  logic signed [31:0]  coord_x,
    input  logic signed [31:0]  coord_y,
    input  logic signed [31:0]  coord_z,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output logic                hit_valid,
    output logic [15:0]         hit_ray,
    output logic [5:0]          hit_triangle,
    output logic [15:0]         hit_slot,
    output logic                last_hit
);
    import rthl_pkg::*;

    localparam int AW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;

    typedef enum logic [1:0] {ST_IDLE, ST_CAST, ST_FINISH} state_t;

    state_t      state_reg;
    logic [6:0]  tiu_reg;
    logic [15:0] cap_reg;
    logic [15:0] hit_count_reg;
    vec_t        org_reg, dir_reg;
    logic [15:0] ray_reg;
    logic [6:0]  issue_cnt_reg;
    logic        rd_valid_reg;
    logic [AW-1:0] rd_idx_reg;
    logic [95:0] mem_anc [MAX_TRIANGLES];
    logic [95:0] mem_e1  [MAX_TRIANGLES];
    logic [95:0] mem_e2  [MAX_TRIANGLES];
    logic [95:0] anc_reg, e1_reg, e2_reg;
    logic        pend_valid_reg;
    logic [5:0]  pend_tri_reg;
    logic [15:0] pend_slot_reg;
    logic        hit_valid_reg, last_hit_reg;
    logic [15:0] hit_ray_reg, hit_slot_reg;
    logic [5:0]  hit_tri_reg;

    logic        accept, issue, load_ok, pipe_busy;
    logic        hit_valid_next, last_hit_next, rd_valid_next;
    logic [6:0]  lim;
    logic [95:0] xyz;
    tag_t        tag_in;
    hit_t        res;

    assign accept  = start && !busy;
    assign lim     = (tiu_reg > 7'(MAX_TRIANGLES)) ? 7'(MAX_TRIANGLES) : tiu_reg;
    assign issue   = (state_reg == ST_CAST) && (issue_cnt_reg < lim);
    assign load_ok = accept && (kind == KIND_LOAD) && ({1'b0, tri_slot} < 7'(MAX_TRIANGLES));
    assign xyz     = {coord_z, coord_y, coord_x};

    // Strobes: a held hit leaves when the next recorded hit arrives, or closes the cast
    assign hit_valid_next = ((state_reg == ST_CAST) && res.valid && res.hit
                             && (hit_count_reg < cap_reg) && pend_valid_reg)
                          || ((state_reg == ST_FINISH) && pend_valid_reg);
    assign last_hit_next  = (state_reg == ST_FINISH) && pend_valid_reg;
    assign rd_valid_next  = issue;

    // Triangle memories: one per vector part, registered read
    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            case (vector_part)
                PART_ANCHOR: mem_anc[tri_slot[AW-1:0]] <= xyz;
                PART_EDGE1:  mem_e1[tri_slot[AW-1:0]]  <= xyz;
                PART_EDGE2:  mem_e2[tri_slot[AW-1:0]]  <= xyz;
                default:     ;
            endcase
        end
        if (issue)
        begin
            anc_reg <= mem_anc[issue_cnt_reg[AW-1:0]];
            e1_reg  <= mem_e1[issue_cnt_reg[AW-1:0]];
            e2_reg  <= mem_e2[issue_cnt_reg[AW-1:0]];
        end
    end

    assign tag_in.valid   = rd_valid_reg;
    assign tag_in.tri_idx = 6'(rd_idx_reg);

    rthl_test u_test (
        .clk      (clk),
        .rst_n    (rst_n),
        .tag_in   (tag_in),
        .anc      (anc_reg),
        .e1       (e1_reg),
        .e2       (e2_reg),
        .org      (org_reg),
        .dir      (dir_reg),
        .res      (res),
        .pipe_busy(pipe_busy)
    );

    // Sequencer, registers and hit output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tiu_reg        <= '0;
            cap_reg        <= COUNT_MAX;
            hit_count_reg  <= '0;
            for (int k = 0; k < 3; k++)
            begin
                org_reg[k] <= '0;
                dir_reg[k] <= '0;
            end
            ray_reg        <= '0;
            issue_cnt_reg  <= '0;
            rd_valid_reg   <= 1'b0;
            rd_idx_reg     <= '0;
            pend_valid_reg <= 1'b0;
            pend_tri_reg   <= '0;
            pend_slot_reg  <= '0;
            hit_valid_reg  <= 1'b0;
            last_hit_reg   <= 1'b0;
            hit_ray_reg    <= '0;
            hit_slot_reg   <= '0;
            hit_tri_reg    <= '0;
        end
        else
        begin
            hit_valid_reg <= hit_valid_next;
            last_hit_reg  <= last_hit_next;
            rd_valid_reg  <= rd_valid_next;

            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_TRI_IN_USE: tiu_reg <= cfg_data[6:0];
                    REG_HIT_CAP:    cap_reg <= cfg_data;
                    default:        ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (kind)
                            KIND_ORIGIN:
                            begin
                                org_reg[0] <= coord_x;
                                org_reg[1] <= coord_y;
                                org_reg[2] <= coord_z;
                            end
                            KIND_CLEAR: hit_count_reg <= '0;
                            KIND_CAST:
                            begin
                                dir_reg[0]    <= coord_x;
                                dir_reg[1]    <= coord_y;
                                dir_reg[2]    <= coord_z;
                                ray_reg       <= ray_number;
                                issue_cnt_reg <= '0;
                                state_reg     <= ST_CAST;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_CAST:
                begin
                    if (issue)
                    begin
                        rd_idx_reg    <= issue_cnt_reg[AW-1:0];
                        issue_cnt_reg <= issue_cnt_reg + 7'd1;
                    end
                    else if (!pipe_busy && !rd_valid_reg)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    // One hit is held back so the last one can be marked
                    if (res.valid && res.hit)
                    begin
                        if (hit_count_reg < cap_reg)
                        begin
                            if (pend_valid_reg)
                            begin
                                hit_ray_reg   <= ray_reg;
                                hit_tri_reg   <= pend_tri_reg;
                                hit_slot_reg  <= pend_slot_reg;
                            end
                            pend_valid_reg <= 1'b1;
                            pend_tri_reg   <= res.tri_idx;
                            pend_slot_reg  <= hit_count_reg;
                        end
                        if (hit_count_reg != COUNT_MAX)
                        begin
                            hit_count_reg <= hit_count_reg + 16'd1;
                        end
                    end
                end
                ST_FINISH:
                begin
                    if (pend_valid_reg)
                    begin
                        hit_ray_reg    <= ray_reg;
                        hit_tri_reg    <= pend_tri_reg;
                        hit_slot_reg   <= pend_slot_reg;
                        pend_valid_reg <= 1'b0;
                    end
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign hit_valid    = hit_valid_reg;
    assign hit_ray      = hit_ray_reg;
    assign hit_triangle = hit_tri_reg;
    assign hit_slot     = hit_slot_reg;
    assign last_hit     = last_hit_reg;

endmodule

// ----- rtl/rthl_checker.sv -----
// Port-level checks on the hit output of the ray and triangle hit list, with bind.
// Depends on ray_triangle_hit_list_defines.svh.
`include "ray_triangle_hit_list_defines.svh"

module rthl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        hit_valid,
    input logic [15:0] hit_ray,
    input logic [15:0] hit_slot,
    input logic        last_hit
);

    // Back-to-back hits of one ray take consecutive slots
    `RTHL_ASSERT_SAME(a_slot_step, hit_valid && $past(hit_valid) && !$past(last_hit), hit_slot == $past(hit_slot) + 16'd1)
    // and carry the same ray number
    `RTHL_ASSERT_SAME(a_ray_same, hit_valid && $past(hit_valid) && !$past(last_hit), hit_ray == $past(hit_ray))
    // The closing hit of a ray is followed by a quiet cycle
    `RTHL_ASSERT_NEXT(a_last_quiet, hit_valid && last_hit, !hit_valid)

endmodule

bind ray_triangle_hit_list rthl_checker u_rthl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .hit_valid(hit_valid),
    .hit_ray  (hit_ray),
    .hit_slot (hit_slot),
    .last_hit (last_hit)
);

// ----- tb/ray_triangle_hit_list_tb.sv -----
// Self-checking testbench for ray_triangle_hit_list: drives loads, origins, casts and clears,
// predicts every hit with full-width triple products and checks the hit strobe item by item.
// Depends on rthl_pkg and the ray_triangle_hit_list RTL only.
`timescale 1ns / 1ps

module ray_triangle_hit_list_tb;
    import rthl_pkg::*;

    localparam int          NUM_TRI    = 64;
    localparam int          NUM_LOADED = 16;   // triangles written before random casting
    localparam logic [1:0]  PART_NONE  = 2'd3;   // not a vector part, ignored on load
    localparam logic [1:0]  REG_SPARE  = 2'd2;   // unmapped register index
    localparam logic [1:0]  REG_LAST   = 2'd3;
    localparam int          Q1         = 65536;  // 1.0 in Q16.16

    typedef logic signed [127:0] wide_t;
    typedef wide_t vec3_t [3];

    typedef struct packed {
        logic [15:0] ray;
        logic [5:0]  tri_idx;
        logic [15:0] slot;
        logic        last;
    } hit_rec_t;

    // Scoreboard: shadow state of the block plus the queue of pending hits
    class hit_scoreboard;
        coord_t      tri_mem [NUM_TRI][3][3];
        coord_t      origin [3];
        logic [15:0] hit_count;
        logic [6:0]  tri_in_use;
        logic [15:0] hit_cap;
        hit_rec_t    pending [$];
        int          errors;
        int          hits_seen;
        int          casts;

        function new();
            foreach (origin[k]) origin[k] = '0;
            hit_count  = '0;
            tri_in_use = '0;
            hit_cap    = COUNT_MAX;
            errors     = 0;
            hits_seen  = 0;
            casts      = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            if (idx == REG_TRI_IN_USE)
                tri_in_use = data[6:0];
            else if (idx == REG_HIT_CAP)
                hit_cap = data;
        endfunction

        function vec3_t cross3(vec3_t a, vec3_t b);
            vec3_t r;
            r[0] = a[1] * b[2] - a[2] * b[1];
            r[1] = a[2] * b[0] - a[0] * b[2];
            r[2] = a[0] * b[1] - a[1] * b[0];
            return r;
        endfunction

        function wide_t dot3(vec3_t a, vec3_t b);
            return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        endfunction

        // Sign-only hit test, no division
        function bit ray_hits(int t, vec3_t dir);
            vec3_t anc, e1, e2, w;
            wide_t d, tn, an, bn;
            for (int k = 0; k < 3; k++)
            begin
                anc[k] = tri_mem[t][PART_ANCHOR][k];
                e1[k]  = tri_mem[t][PART_EDGE1][k];
                e2[k]  = tri_mem[t][PART_EDGE2][k];
                w[k]   = wide_t'(origin[k]) - anc[k];
            end
            d = dot3(cross3(e2, e1), dir);
            if (d == 0)
                return 0;
            tn = dot3(cross3(e1, e2), w);
            an = dot3(cross3(e2, w), dir);
            bn = dot3(cross3(w, e1), dir);
            if (d < 0)
            begin
                d = -d; tn = -tn; an = -an; bn = -bn;
            end
            if (tn <= 0 || an < 0 || bn < 0)
                return 0;
            return (d - (an + bn)) >= 0;
        endfunction

        // Apply one accepted item; a cast queues its hits
        function void note_item(logic [1:0] kind, logic [5:0] slot, logic [1:0] part,
                                logic [15:0] ray, coord_t x, coord_t y, coord_t z);
            vec3_t    dir;
            hit_rec_t rec;
            int       lim, n;
            case (kind)
                KIND_LOAD:
                    if (part != PART_NONE)
                    begin
                        tri_mem[slot][part][0] = x;
                        tri_mem[slot][part][1] = y;
                        tri_mem[slot][part][2] = z;
                    end
                KIND_ORIGIN:
                begin
                    origin[0] = x; origin[1] = y; origin[2] = z;
                end
                KIND_CLEAR:
                    hit_count = '0;
                default:
                begin
                    casts++;
                    dir[0] = x; dir[1] = y; dir[2] = z;
                    lim = (int'(tri_in_use) > NUM_TRI) ? NUM_TRI : int'(tri_in_use);
                    n = 0;
                    for (int t = 0; t < lim; t++)
                    begin
                        if (!ray_hits(t, dir))
                            continue;
                        if (hit_count < hit_cap)
                        begin
                            rec.ray = ray; rec.tri_idx = t[5:0];
                            rec.slot = hit_count; rec.last = 1'b0;
                            pending.push_back(rec);
                            n++;
                        end
                        if (hit_count != COUNT_MAX)
                            hit_count++;
                    end
                    if (n > 0)
                        pending[pending.size() - 1].last = 1'b1;
                end
            endcase
        endfunction

        function void check_hit(hit_rec_t got);
            hit_rec_t want;
            hits_seen++;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected hit ray %0d tri %0d slot %0d last %0b",
                             $realtime, got.ray, got.tri_idx, got.slot, got.last);
                return;
            end
            want = pending.pop_front();
            if (got != want)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("%0t: hit mismatch exp ray %0d tri %0d slot %0d last %0b",
                             $realtime, want.ray, want.tri_idx, want.slot, want.last);
                    $display("    got ray %0d tri %0d slot %0d last %0b",
                             got.ray, got.tri_idx, got.slot, got.last);
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  kind = '0;
    logic [5:0]  tri_slot = '0;
    logic [1:0]  vector_part = '0;
    logic [15:0] ray_number = '0;
    coord_t      coord_x = '0;
    coord_t      coord_y = '0;
    coord_t      coord_z = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        hit_valid;
    logic [15:0] hit_ray;
    logic [5:0]  hit_triangle;
    logic [15:0] hit_slot;
    logic        last_hit;

    hit_scoreboard sb = new();
    int            idle_pct = 15;
    int            items_sent = 0;

    always #5 clk = ~clk;

    ray_triangle_hit_list i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .kind(kind), .tri_slot(tri_slot), .vector_part(vector_part),
        .ray_number(ray_number), .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .hit_valid(hit_valid), .hit_ray(hit_ray),
        .hit_triangle(hit_triangle), .hit_slot(hit_slot), .last_hit(last_hit)
    );

    // Hit monitor
    always @(posedge clk)
    begin
        hit_rec_t got;
        if (rst_n && hit_valid)
        begin
            got.ray = hit_ray; got.tri_idx = hit_triangle;
            got.slot = hit_slot; got.last = last_hit;
            sb.check_hit(got);
        end
    end

    // One item through the start/busy handshake, with random sender gaps
    task automatic send(logic [1:0] k, logic [5:0] s, logic [1:0] p, logic [15:0] r,
                        coord_t x, coord_t y, coord_t z);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1; kind = k; tri_slot = s; vector_part = p;
        ray_number = r; coord_x = x; coord_y = y; coord_z = z;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(k, s, p, r, x, y, z);
        items_sent++;
    endtask

    // Drain all pending hits, then let any hitless cast finish
    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        while (sb.pending.size() != 0 || busy)
            @(posedge clk);
        repeat (90) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        settle();
        @(negedge clk);
        cfg_valid = 1'b1; cfg_index = idx; cfg_data = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic coord_t q_range(int lo, int hi);
        return coord_t'($urandom_range(hi - lo, 0)) + lo;
    endfunction

    // Triangle roughly facing +z, sometimes with flipped winding
    task automatic load_triangle(int t);
        coord_t ex = q_range(4 * Q1, 10 * Q1);
        if ($urandom_range(1)) ex = -ex;
        send(KIND_LOAD, t[5:0], PART_ANCHOR, 16'($urandom), q_range(-6 * Q1, 2 * Q1),
             q_range(-6 * Q1, 2 * Q1), q_range(2 * Q1, 20 * Q1));
        send(KIND_LOAD, t[5:0], PART_EDGE1, 16'($urandom), ex, q_range(-Q1, Q1),
             q_range(-Q1, Q1));
        send(KIND_LOAD, t[5:0], PART_EDGE2, 16'($urandom), q_range(-Q1, Q1),
             q_range(4 * Q1, 10 * Q1), q_range(-Q1, Q1));
    endtask

    task automatic aimed_cast();
        send(KIND_ORIGIN, 6'($urandom), 2'($urandom), 16'($urandom),
             q_range(-3 * Q1, 3 * Q1), q_range(-3 * Q1, 3 * Q1), q_range(-2 * Q1, 2 * Q1));
        send(KIND_CAST, 6'($urandom), 2'($urandom), 16'($urandom), q_range(-Q1 / 2, Q1 / 2),
             q_range(-Q1 / 2, Q1 / 2), ($urandom_range(7) == 0) ? -Q1 : Q1);
    endtask

    // Mostly aimed rays, some reloads, clears and raw noise
    task automatic random_burst(int count);
        int sel;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 60)
                aimed_cast();
            else if (sel < 72)
                load_triangle($urandom_range(NUM_LOADED - 1));
            else if (sel < 77)
                send(KIND_CLEAR, 6'($urandom), 2'($urandom), 16'($urandom),
                     $urandom, $urandom, $urandom);
            else if (sel < 88)
                send(2'($urandom), 6'($urandom), 2'($urandom), 16'($urandom),
                     $urandom, $urandom, $urandom);
            else
                send(KIND_CAST, 6'($urandom), 2'($urandom), 16'($urandom),
                     $urandom, $urandom, $urandom);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: no triangles in use, then three with a hit pair and a degenerate one
        send(KIND_CAST, 6'd0, 2'd0, 16'hFFFF, 32'sd0, 32'sd0, Q1);
        send(KIND_LOAD, 6'd0, PART_ANCHOR, 16'd0, -4 * Q1, -4 * Q1, 10 * Q1);
        send(KIND_LOAD, 6'd0, PART_EDGE1, 16'd0, 8 * Q1, 32'sd0, 32'sd0);
        send(KIND_LOAD, 6'd0, PART_EDGE2, 16'd0, 32'sd0, 8 * Q1, 32'sd0);
        send(KIND_LOAD, 6'd1, PART_ANCHOR, 16'd0, -2 * Q1, -2 * Q1, 5 * Q1);
        send(KIND_LOAD, 6'd1, PART_EDGE1, 16'd0, 32'sd0, 6 * Q1, 32'sd0);
        send(KIND_LOAD, 6'd1, PART_EDGE2, 16'd0, 6 * Q1, 32'sd0, 32'sd0);
        // edges parallel: zero denominator
        send(KIND_LOAD, 6'd2, PART_ANCHOR, 16'd0, -Q1, -Q1, 3 * Q1);
        send(KIND_LOAD, 6'd2, PART_EDGE1, 16'd0, 4 * Q1, 4 * Q1, 32'sd0);
        send(KIND_LOAD, 6'd2, PART_EDGE2, 16'd0, 4 * Q1, 4 * Q1, 32'sd0);
        // bad vector part must not disturb triangle 0
        send(KIND_LOAD, 6'd0, PART_NONE, 16'd0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        write_reg(REG_TRI_IN_USE, 16'd3);
        send(KIND_ORIGIN, 6'd0, 2'd0, 16'd0, 32'sd0, 32'sd0, 32'sd0);
        send(KIND_CAST, 6'd63, 2'd3, 16'd1, 32'sd0, 32'sd0, Q1);
        send(KIND_CAST, 6'd0, 2'd0, 16'hFFFF, 32'sd0, 32'sd0, -Q1);
        send(KIND_CLEAR, 6'd0, 2'd0, 16'd0, 32'sd0, 32'sd0, 32'sd0);
        // extreme coordinates
        send(KIND_ORIGIN, 6'd0, 2'd0, 16'd0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        send(KIND_CAST, 6'd0, 2'd0, 16'd2, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        send(KIND_CAST, 6'd0, 2'd0, 16'd3, 32'h80000000, 32'h80000000, 32'h80000000);

        // Fill the first triangles; every count in use stays within them
        for (int t = 0; t < NUM_LOADED; t++)
            load_triangle(t);

        // Three phases: light gaps, heavy gaps, none
        write_reg(REG_TRI_IN_USE, 16'(NUM_LOADED));
        write_reg(REG_SPARE, 16'hFFFF);
        idle_pct = 15;
        random_burst(14);

        write_reg(REG_TRI_IN_USE, 16'd12);
        write_reg(REG_HIT_CAP, 16'd7);
        idle_pct = 63;
        send(KIND_CLEAR, 6'd0, 2'd0, 16'd0, 32'sd0, 32'sd0, 32'sd0);
        random_burst(14);

        write_reg(REG_HIT_CAP, 16'd0);
        write_reg(REG_LAST, 16'h0000);
        idle_pct = 0;
        aimed_cast();
        write_reg(REG_TRI_IN_USE, 16'd9);
        write_reg(REG_HIT_CAP, 16'hFFFF);
        send(KIND_CLEAR, 6'd0, 2'd0, 16'd0, 32'sd0, 32'sd0, 32'sd0);
        random_burst(14);

        settle();
        $display("Sent %0d items including %0d ray casts; %0d hits checked, %0d mismatches.",
                 items_sent, sb.casts, sb.hits_seen, sb.errors);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("Timeout waiting for the block");
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/rthl_pkg.sv
rtl/rthl_cell.sv
rtl/rthl_dot.sv
rtl/rthl_test.sv
rtl/ray_triangle_hit_list.sv
rtl/rthl_checker.sv
tb/ray_triangle_hit_list_tb.sv
